[sv/mava_pkg.sv]
// Package for the mesh area and volume accumulator.
// Holds shared widths and limits; no dependencies.
package mava_pkg;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int LANE_STRIDE     = 16;
    localparam int VERTEX_W        = 48;
    localparam int AREA_W          = 48;
    localparam int VOL_W           = 60;
    localparam int VSUM_W          = 64;
endpackage

[sv/mava_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
// Stand-alone; used by mesh_area_volume_accumulator.
module mava_isqrt #(
    parameter int ROOT_W = 35
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2*ROOT_W-1:0]   i_radicand,
    output logic                  o_done,
    output logic [ROOT_W-1:0]     o_root
);
    localparam int RAD_W = 2 * ROOT_W;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0] r_rem, r_root, r_one;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [RAD_W-1:0] trial;

    assign trial  = r_root + r_one;
    assign o_done = r_done;
    assign o_root = r_root[ROOT_W-1:0];

    // Classic digit-by-digit root: one trial subtract per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_radicand;
                r_root <= '0;
                r_one  <= RAD_W'(1) << (RAD_W - 2);
                r_cnt  <= CNT_W'(ROOT_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_rem >= trial) begin
                    r_rem  <= r_rem - trial;
                    r_root <= (r_root >> 1) + r_one;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_one <= r_one >> 2;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

[sv/mesh_area_volume_accumulator.sv]
// Top level of the mesh area and volume accumulator.
// Depends on mava_pkg and mava_isqrt.
//
// Usage: one triangular face of a closed polyhedron per input transfer
// (i_valid / o_stall), with the three vertices, an inner point and a
// last-face flag. Each face, from one transfer to the next, goes through
// the transfer cycle, a phase in which 15 products pass through a single
// shared signed multiplier and the last one is folded in, the bit-serial
// square root (start, 35 steps, finish) and an update step. A last face
// adds the reciprocal multiplication by one sixth on the same multiplier
// and a step that loads the result register before the next face is taken.
// o_stall is high from the transfer until the face is fully processed, so
// one face is in work at a time.
// A result transfer (o_valid / i_stall) follows each last face only; it
// is held in an output register and the next faces are accepted while it
// waits. A later last face waits in its final cycle until the register is
// free. Reset clears the sums and the flag and sets the orientation
// register to one. The orientation register is written with i_cfg_we and
// may only be changed while the block is idle.
module mesh_area_volume_accumulator #(
    parameter int COORD_WIDTH = mava_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [mava_pkg::VERTEX_W-1:0] i_vertex_a,
    input  logic [mava_pkg::VERTEX_W-1:0] i_vertex_b,
    input  logic [mava_pkg::VERTEX_W-1:0] i_vertex_c,
    input  logic [mava_pkg::VERTEX_W-1:0] i_inner_point,
    input  logic                          i_last_face,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [mava_pkg::AREA_W-1:0]   o_surface_area,
    output logic [mava_pkg::VOL_W-1:0]    o_enclosed_volume,
    output logic                          o_saturated
);
    import mava_pkg::*;

    localparam int DW        = COORD_WIDTH + 1;
    localparam int NW        = 2 * DW + 1;
    localparam int MW        = (NW > 33) ? NW : 33;
    localparam int PW        = 2 * MW;
    localparam int SW        = 4;
    localparam int HALF      = 32;
    localparam int DIV_STEPS = 4;
    localparam int DIV_W     = $clog2(DIV_STEPS + 1);
    localparam int RCP_SHIFT = 2;

    // Product sequence through the shared multiplier.
    localparam logic [SW-1:0] ST_N0A = 4'd0,  ST_N0B = 4'd1;
    localparam logic [SW-1:0] ST_N1A = 4'd2,  ST_N1B = 4'd3;
    localparam logic [SW-1:0] ST_N2A = 4'd4,  ST_N2B = 4'd5;
    localparam logic [SW-1:0] ST_SQ0 = 4'd6,  ST_SQ1 = 4'd7,  ST_SQ2 = 4'd8;
    localparam logic [SW-1:0] ST_DT0 = 4'd9,  ST_DT1 = 4'd10, ST_DT2 = 4'd11;
    localparam logic [SW-1:0] ST_SD0 = 4'd12, ST_SD1 = 4'd13, ST_SD2 = 4'd14;
    localparam logic [SW-1:0] ST_END = 4'd15;

    // Reciprocal of six as a 64-bit fraction scaled by 2^66, in two halves.
    localparam logic [HALF-1:0] RCP_LO = 32'hAAAA_AAAB;
    localparam logic [HALF-1:0] RCP_HI = 32'hAAAA_AAAA;

    localparam logic [AREA_W-1:0] AREA_MAX = '1;
    localparam logic [VOL_W-1:0]  VOL_MAX  = '1;
    localparam logic signed [VSUM_W:0] VSUM_HI = (VSUM_W+1)'({1'b0, {(VSUM_W-1){1'b1}}});
    localparam logic signed [VSUM_W:0] VSUM_LO = (VSUM_W+1)'({2'b11, {(VSUM_W-1){1'b0}}});

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_SQRT, S_ACC, S_DIV, S_OUT} t_state;

    t_state r_state;
    logic   r_orient, r_mode, r_last;
    logic signed [COORD_WIDTH-1:0] r_a  [3];
    logic signed [DW-1:0]          r_d1 [3];
    logic signed [DW-1:0]          r_d2 [3];
    logic signed [DW-1:0]          r_pa [3];
    logic signed [NW-1:0]          r_n  [3];
    logic [SW-1:0]         r_step, r_pstep;
    logic                  r_pv;
    logic signed [PW-1:0]  r_prod, r_dot, r_side;
    logic [2*NW-1:0]       r_sq;
    logic                  r_sq_start;
    logic [AREA_W-1:0]     r_area;
    logic signed [VSUM_W-1:0] r_vsum;
    logic                  r_clip;
    logic [VSUM_W-1:0]     r_dq;
    logic [PW-1:0]         r_racc;
    logic [DIV_W-1:0]      r_dcnt;
    logic                  r_ovalid, r_osat;
    logic [AREA_W-1:0]     r_oarea;
    logic [VOL_W-1:0]      r_ovol;

    logic                  sq_done;
    logic [NW-1:0]         sq_root;
    logic signed [MW-1:0]  op_x, op_y;
    logic [AREA_W:0]       area_sum;
    logic                  area_clip;
    logic signed [PW-1:0]  dot_term;
    logic signed [VSUM_W:0] vsum_ext;
    logic signed [VSUM_W-1:0] n_vsum;
    logic                  n_vclip;
    logic [PW-1:0]         quot;
    logic                  accept;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_surface_area    = r_oarea;
    assign o_enclosed_volume = r_ovol;
    assign o_saturated       = r_osat;

    mava_isqrt #(.ROOT_W(NW)) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sq_start),
        .i_radicand (r_sq),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        op_x = '0;
        op_y = '0;
        if (r_state == S_DIV) begin
            // Partial products of the magnitude and the reciprocal of six.
            case (r_dcnt[1:0])
                2'd0: begin op_x = MW'(r_dq[HALF-1:0]);        op_y = MW'(RCP_LO); end
                2'd1: begin op_x = MW'(r_dq[HALF-1:0]);        op_y = MW'(RCP_HI); end
                2'd2: begin op_x = MW'(r_dq[VSUM_W-1:HALF]);   op_y = MW'(RCP_LO); end
                default: begin op_x = MW'(r_dq[VSUM_W-1:HALF]); op_y = MW'(RCP_HI); end
            endcase
        end else begin
            case (r_step)
                ST_N0A: begin op_x = MW'(r_d1[1]); op_y = MW'(r_d2[2]); end
                ST_N0B: begin op_x = MW'(r_d1[2]); op_y = MW'(r_d2[1]); end
                ST_N1A: begin op_x = MW'(r_d1[2]); op_y = MW'(r_d2[0]); end
                ST_N1B: begin op_x = MW'(r_d1[0]); op_y = MW'(r_d2[2]); end
                ST_N2A: begin op_x = MW'(r_d1[0]); op_y = MW'(r_d2[1]); end
                ST_N2B: begin op_x = MW'(r_d1[1]); op_y = MW'(r_d2[0]); end
                ST_SQ0: begin op_x = MW'(r_n[0]); op_y = MW'(r_n[0]); end
                ST_SQ1: begin op_x = MW'(r_n[1]); op_y = MW'(r_n[1]); end
                ST_SQ2: begin op_x = MW'(r_n[2]); op_y = MW'(r_n[2]); end
                ST_DT0: begin op_x = MW'(r_a[0]); op_y = MW'(r_n[0]); end
                ST_DT1: begin op_x = MW'(r_a[1]); op_y = MW'(r_n[1]); end
                ST_DT2: begin op_x = MW'(r_a[2]); op_y = MW'(r_n[2]); end
                ST_SD0: begin op_x = MW'(r_pa[0]); op_y = MW'(r_n[0]); end
                ST_SD1: begin op_x = MW'(r_pa[1]); op_y = MW'(r_n[1]); end
                ST_SD2: begin op_x = MW'(r_pa[2]); op_y = MW'(r_n[2]); end
                default: begin op_x = '0; op_y = '0; end
            endcase
        end
    end

    // Face update: area clamp, orientation and saturating volume add; also the quotient shift.
    always_comb begin
        area_sum  = {1'b0, r_area} + (AREA_W+1)'(sq_root >> 1);
        area_clip = (area_sum > (AREA_W+1)'(AREA_MAX));
        dot_term  = r_dot;
        if (r_mode && !(r_side > 0)) begin
            dot_term = -r_dot;
        end
        vsum_ext = (VSUM_W+1)'(r_vsum) + (VSUM_W+1)'(dot_term);
        n_vclip  = 1'b0;
        if (vsum_ext > VSUM_HI) begin
            n_vsum  = VSUM_HI[VSUM_W-1:0];
            n_vclip = 1'b1;
        end else if (vsum_ext < VSUM_LO) begin
            n_vsum  = VSUM_LO[VSUM_W-1:0];
            n_vclip = 1'b1;
        end else begin
            n_vsum = vsum_ext[VSUM_W-1:0];
        end
        quot = r_racc >> RCP_SHIFT;
    end

    // Sequencer, datapath registers and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_orient   <= 1'b1;
            r_area     <= '0;
            r_vsum     <= '0;
            r_clip     <= 1'b0;
            r_ovalid   <= 1'b0;
            r_pv       <= 1'b0;
            r_sq_start <= 1'b0;
        end else begin
            r_sq_start <= 1'b0;
            if (i_cfg_we) begin
                r_orient <= i_cfg_data;
            end
            if (r_ovalid && !i_stall && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        for (int k = 0; k < 3; k++) begin
                            r_a[k]  <= i_vertex_a[LANE_STRIDE*k +: COORD_WIDTH];
                            r_d1[k] <= DW'($signed(i_vertex_b[LANE_STRIDE*k +: COORD_WIDTH]))
                                     - DW'($signed(i_vertex_a[LANE_STRIDE*k +: COORD_WIDTH]));
                            r_d2[k] <= DW'($signed(i_vertex_c[LANE_STRIDE*k +: COORD_WIDTH]))
                                     - DW'($signed(i_vertex_a[LANE_STRIDE*k +: COORD_WIDTH]));
                            r_pa[k] <= DW'($signed(i_inner_point[LANE_STRIDE*k +: COORD_WIDTH]))
                                     - DW'($signed(i_vertex_a[LANE_STRIDE*k +: COORD_WIDTH]));
                        end
                        r_mode  <= r_orient;
                        r_last  <= i_last_face;
                        r_step  <= ST_N0A;
                        r_pv    <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // Issue one product a cycle, fold the previous one in.
                    r_prod  <= op_x * op_y;
                    r_pstep <= r_step;
                    r_pv    <= (r_step != ST_END);
                    if (r_step != ST_END) begin
                        r_step <= r_step + SW'(1);
                    end
                    if (r_pv) begin
                        case (r_pstep) inside
                            ST_N0A: r_n[0] <= r_prod[NW-1:0];
                            ST_N0B: r_n[0] <= r_n[0] - r_prod[NW-1:0];
                            ST_N1A: r_n[1] <= r_prod[NW-1:0];
                            ST_N1B: r_n[1] <= r_n[1] - r_prod[NW-1:0];
                            ST_N2A: r_n[2] <= r_prod[NW-1:0];
                            ST_N2B: r_n[2] <= r_n[2] - r_prod[NW-1:0];
                            ST_SQ0: r_sq   <= r_prod[2*NW-1:0];
                            ST_SQ1, ST_SQ2: r_sq <= r_sq + r_prod[2*NW-1:0];
                            ST_DT0: r_dot  <= r_prod;
                            ST_DT1, ST_DT2: r_dot <= r_dot + r_prod;
                            ST_SD0: r_side <= r_prod;
                            default: r_side <= r_side + r_prod;
                        endcase
                        if (r_pstep == ST_SD2) begin
                            r_sq_start <= 1'b1;
                            r_state    <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    if (sq_done) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_vsum <= n_vsum;
                    if (area_clip) begin
                        r_area <= AREA_MAX;
                    end else begin
                        r_area <= area_sum[AREA_W-1:0];
                    end
                    r_clip  <= r_clip || area_clip || n_vclip;
                    r_dq    <= n_vsum[VSUM_W-1] ? VSUM_W'(-n_vsum) : VSUM_W'(n_vsum);
                    r_dcnt  <= '0;
                    r_state <= r_last ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    // Multiply by the reciprocal of six, one partial product a
                    // cycle, keeping only the bits above the discarded low word.
                    r_prod <= op_x * op_y;
                    r_dcnt <= r_dcnt + DIV_W'(1);
                    case (r_dcnt)
                        DIV_W'(1): r_racc <= r_prod;
                        DIV_W'(2): r_racc <= (r_racc >> HALF) + r_prod;
                        DIV_W'(3): r_racc <= r_racc + r_prod;
                        DIV_W'(DIV_STEPS): begin
                            r_racc  <= (r_racc >> HALF) + r_prod;
                            r_state <= S_OUT;
                        end
                        default: ;
                    endcase
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_oarea  <= r_area;
                        if (|quot[PW-1:VOL_W]) begin
                            r_ovol <= VOL_MAX;
                            r_osat <= 1'b1;
                        end else begin
                            r_ovol <= quot[VOL_W-1:0];
                            r_osat <= r_clip;
                        end
                        r_area  <= '0;
                        r_vsum  <= '0;
                        r_clip  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The accepted face keeps the input side stalled on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_stall)
        else $error("block ready straight after accepting a face");

    // The root finishes only while the sequencer waits for it.
    a_root_in_sqrt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == S_SQRT))
        else $error("square root finished outside its state");

    // The reciprocal multiplication never runs past its last partial product.
    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dcnt <= DIV_W'(DIV_STEPS)))
        else $error("division step count out of range");

    // A result is loaded only when the output register is free or drains.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_ovalid && i_stall) |=> (r_state == S_OUT))
        else $error("result overwritten while stalled");
endmodule
